FILE: rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Types, codes and defaults shared by the palette slot allocator files.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int DEF_SLOT_COUNT    = 16;
	localparam int DEF_COLOUR_BYTES  = 6;
	localparam int NUM_COLOUR_FIELDS = 6;
	localparam int MAX_COLOUR_BYTES  = 8;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// item kinds
	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;

	// pool numbers
	localparam logic [1:0] POOL_ONE = 2'd1;
	localparam logic [1:0] POOL_TWO = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_POOL_ONE_FIRST  = 3'd0;
	localparam logic [2:0] CFG_POOL_ONE_END    = 3'd1;
	localparam logic [2:0] CFG_POOL_TWO_FIRST  = 3'd2;
	localparam logic [2:0] CFG_POOL_TWO_END    = 3'd3;
	localparam logic [2:0] CFG_MATCH_TOLERANCE = 3'd4;

	// register reset values
	localparam logic [3:0] RST_POOL_ONE_FIRST  = 4'd13;
	localparam logic [4:0] RST_POOL_ONE_END    = 5'd15;
	localparam logic [3:0] RST_POOL_TWO_FIRST  = 4'd4;
	localparam logic [4:0] RST_POOL_TWO_END    = 5'd12;
	localparam logic [7:0] RST_MATCH_TOLERANCE = 8'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FREE_SCAN,
		ST_MATCH_RD,
		ST_MATCH_CMP,
		ST_REL_RD,
		ST_REL_WR,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/sps_ram.sv
// ----------------------------------------------------------------------------
// sps_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: rtl/shared_palette_slot_allocator.sv
// allocate: a free scan over the used bits from the pool's first slot, then, if no
// slot is free, a share scan that reads and compares each slot in turn through the
// single slot RAM port. release: a read, then a write; clear and others: straight to done.
// one item at a time; the next item is taken once the result is registered.
// reset clears the used flags at once (no clearing pass) and loads the
// register defaults; slot contents are only read for used slots.
// ----------------------------------------------------------------------------
// shared_palette_slot_allocator
// Reference-counted colour slot table with first-free allocate, tolerant
// sharing, release and clear, run by a small sequencer over one slot RAM.
// ----------------------------------------------------------------------------
module shared_palette_slot_allocator
	import sps_pkg::*;
#(
	parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
	parameter int COLOUR_BYTES = DEF_COLOUR_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // pool[1:0], colour_a..colour_f[49:2], release_slot[53:50]
	input  logic [1:0]  s_tuser,  // kind[1:0]

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // slot_index[3:0]
	output logic [1:0]  m_tuser,  // granted[0], was_shared[1]

	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int IW  = $clog2(SLOT_COUNT);
	localparam int CW  = (IW + 1 > 5) ? IW + 1 : 5;
	localparam int CBW = COLOUR_BYTES * 8;
	localparam int DW  = CBW + 8;

	state_t state_q, state_d;

	logic [3:0] p1_first_q, p2_first_q;
	logic [4:0] p1_end_q, p2_end_q;
	logic [7:0] tol_q;

	logic [47:0]           colours_q;
	logic [CW-1:0]         idx_q, first_q, end_q;
	logic [SLOT_COUNT-1:0] used_q;
	logic                  res_granted_q, res_shared_q;
	logic [3:0]            res_slot_q;
	logic                  out_valid_q, out_granted_q, out_shared_q;
	logic [3:0]            out_slot_q;

	logic          in_acc, out_free, at_end, cur_used, close;
	logic          pool_ok, rel_ok;
	logic [1:0]    in_kind, in_pool;
	logic [3:0]    in_rel;
	logic [CW-1:0] sel_first, sel_end, sel_end_ext;
	logic [IW-1:0] addr;

	logic          ram_we;
	logic [DW-1:0] ram_wdata, ram_rdata;
	logic [CBW-1:0] want;
	logic [7:0]    rd_refs, new_refs;
	logic          idx_inc, idx_rewind, grant, share, used_set, used_clr;

	logic [MAX_COLOUR_BYTES*8-1:0] colours_pad;

	assign in_kind  = s_tuser[1:0];
	assign in_pool  = s_tdata[1:0];
	assign in_rel   = s_tdata[53:50];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign addr     = idx_q[IW-1:0];
	assign at_end   = (idx_q >= end_q);
	assign cur_used = used_q[addr];
	assign rd_refs  = ram_rdata[DW-1 -: 8];
	assign rel_ok   = (CW'(in_rel) < CW'(SLOT_COUNT));
	assign pool_ok  = (in_pool == POOL_ONE) || (in_pool == POOL_TWO);

	// range of the requested pool, end clamped to the table size
	always_comb begin
		if (in_pool == POOL_ONE) begin
			sel_first   = CW'(p1_first_q);
			sel_end_ext = CW'(p1_end_q);
		end else begin
			sel_first   = CW'(p2_first_q);
			sel_end_ext = CW'(p2_end_q);
		end
		sel_end = (sel_end_ext > CW'(SLOT_COUNT)) ? CW'(SLOT_COUNT) : sel_end_ext;
	end

	// requested bytes; bytes past the six fields are zero
	assign colours_pad = {{(MAX_COLOUR_BYTES * 8 - 48){1'b0}}, colours_q};

	always_comb begin
		for (int b = 0; b < COLOUR_BYTES; b++) begin
			want[b*8 +: 8] = (b < NUM_COLOUR_FIELDS) ? colours_pad[b*8 +: 8] : 8'd0;
		end
	end

	// per-byte distance test against the stored slot
	always_comb begin
		logic [7:0] w, h, d;
		close = 1'b1;
		for (int b = 0; b < COLOUR_BYTES; b++) begin
			w = want[b*8 +: 8];
			h = ram_rdata[b*8 +: 8];
			d = (w > h) ? (w - h) : (h - w);
			if (d >= tol_q) begin
				close = 1'b0;
			end
		end
	end

	assign new_refs = (rd_refs == COUNT_MAX) ? rd_refs : (rd_refs + 8'd1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					priority if (in_kind == KIND_ALLOC && pool_ok) begin
						state_d = ST_FREE_SCAN;
					end else if (in_kind == KIND_RELEASE && rel_ok) begin
						state_d = ST_REL_RD;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FREE_SCAN: begin
				if (at_end) begin
					state_d = ST_MATCH_RD;
				end else if (!cur_used) begin
					state_d = ST_DONE;
				end
			end
			ST_MATCH_RD:  state_d = at_end ? ST_DONE : ST_MATCH_CMP;
			ST_MATCH_CMP: state_d = (cur_used && close) ? ST_DONE : ST_MATCH_RD;
			ST_REL_RD:    state_d = ST_REL_WR;
			ST_REL_WR:    state_d = ST_DONE;
			ST_DONE:      state_d = out_free ? ST_IDLE : ST_DONE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// sequencer controls
	always_comb begin
		ram_we     = 1'b0;
		ram_wdata  = {8'd1, want};
		idx_inc    = 1'b0;
		idx_rewind = 1'b0;
		grant      = 1'b0;
		share      = 1'b0;
		used_set   = 1'b0;
		used_clr   = 1'b0;
		unique case (state_q)
			ST_FREE_SCAN: begin
				if (at_end) begin
					idx_rewind = 1'b1;
				end else if (!cur_used) begin
					ram_we   = 1'b1;
					used_set = 1'b1;
					grant    = 1'b1;
				end else begin
					idx_inc = 1'b1;
				end
			end
			ST_MATCH_CMP: begin
				if (cur_used && close) begin
					ram_we    = 1'b1;
					ram_wdata = {new_refs, ram_rdata[CBW-1:0]};
					grant     = 1'b1;
					share     = 1'b1;
				end else begin
					idx_inc = 1'b1;
				end
			end
			ST_REL_WR: begin
				if (cur_used) begin
					ram_we    = 1'b1;
					ram_wdata = {rd_refs - 8'd1, ram_rdata[CBW-1:0]};
					used_clr  = (rd_refs <= 8'd1);
				end
			end
			default: begin
			end
		endcase
	end

	sps_ram #(
		.WIDTH(DW),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			used_q        <= '0;
			out_valid_q   <= 1'b0;
			res_granted_q <= 1'b0;
			res_shared_q  <= 1'b0;
			p1_first_q    <= RST_POOL_ONE_FIRST;
			p1_end_q      <= RST_POOL_ONE_END;
			p2_first_q    <= RST_POOL_TWO_FIRST;
			p2_end_q      <= RST_POOL_TWO_END;
			tol_q         <= RST_MATCH_TOLERANCE;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_POOL_ONE_FIRST:  p1_first_q <= cfg_data[3:0];
					CFG_POOL_ONE_END:    p1_end_q   <= cfg_data[4:0];
					CFG_POOL_TWO_FIRST:  p2_first_q <= cfg_data[3:0];
					CFG_POOL_TWO_END:    p2_end_q   <= cfg_data[4:0];
					CFG_MATCH_TOLERANCE: tol_q      <= cfg_data;
					default: begin
					end
				endcase
			end

			if (in_acc) begin
				res_granted_q <= 1'b0;
				res_shared_q  <= 1'b0;
				if (in_kind == KIND_CLEAR) begin
					used_q <= '0;
				end
			end else begin
				if (grant) begin
					res_granted_q <= 1'b1;
				end
				if (share) begin
					res_shared_q <= 1'b1;
				end
				if (used_set) begin
					used_q[addr] <= 1'b1;
				end
				if (used_clr) begin
					used_q[addr] <= 1'b0;
				end
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and scan registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			colours_q <= s_tdata[49:2];
			first_q   <= sel_first;
			end_q     <= sel_end;
			idx_q     <= (in_kind == KIND_RELEASE) ? CW'(in_rel) : sel_first;
		end else if (idx_rewind) begin
			idx_q <= first_q;
		end else if (idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end

		if (in_acc) begin
			res_slot_q <= 4'd0;
		end else if (grant) begin
			res_slot_q <= idx_q[3:0];
		end

		if (state_q == ST_DONE && out_free) begin
			out_granted_q <= res_granted_q;
			out_shared_q  <= res_shared_q;
			out_slot_q    <= res_slot_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_slot_q};
	assign m_tuser  = {out_shared_q, out_granted_q};

endmodule
